>>> src/assert_macros.svh
// Assertion macros shared by the cipher RTL.
// Depends on nothing; the SYNTH macro selects empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> src/tbc_pkg.sv
// Shared types, constants and the round-sum function of the TEA cipher unit.
// Depends on nothing.
package tbc_pkg;

    localparam int WORD_W      = 32;
    localparam int ROUND_COUNT = 32;
    localparam int STAGE_COUNT = 2 * ROUND_COUNT;
    localparam int CFG_INDEX_W = 4;

    localparam logic [WORD_W-1:0] ROUND_DELTA = 32'h9e37_79b9;

    // Register indexes of the key words.
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD0 = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD1 = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD2 = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD3 = 4'd3;

    typedef struct packed {
        logic [WORD_W-1:0] word3;
        logic [WORD_W-1:0] word2;
        logic [WORD_W-1:0] word1;
        logic [WORD_W-1:0] word0;
    } key_t;

    typedef struct packed {
        logic              func;
        logic [WORD_W-1:0] second;
        logic [WORD_W-1:0] first;
    } blk_t;

    // Running sum seen in round rnd (from 0) of an encryption: delta * (rnd + 1).
    // Only ever called with elaboration-time constants.
    function automatic logic [WORD_W-1:0] round_sum(input int rnd);
        logic [2*WORD_W-1:0] prod;
        prod = (2*WORD_W)'(ROUND_DELTA) * (2*WORD_W)'(rnd + 1);
        return prod[WORD_W-1:0];
    endfunction

endpackage

>>> src/tbc_key_regs.sv
// Key register file of the TEA cipher unit, written over the configuration channel.
// Depends on tbc_pkg.
module tbc_key_regs
    import tbc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    output key_t                   key
);

    key_t key_reg;
    key_t key_next;

    assign cfg_ready = 1'b1;
    assign key       = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KEY_WORD0: key_next.word0 = cfg_data;
                REG_KEY_WORD1: key_next.word1 = cfg_data;
                REG_KEY_WORD2: key_next.word2 = cfg_data;
                REG_KEY_WORD3: key_next.word3 = cfg_data;
                default:       key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

endmodule

>>> src/tbc_stage.sv
// One half-round pipeline stage of the TEA cipher unit, with its own valid bit.
// Depends on tbc_pkg.
module tbc_stage
    import tbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  key_t              key,
    input  logic [WORD_W-1:0] sum_enc,
    input  logic [WORD_W-1:0] sum_dec,
    input  logic              phase,
    input  logic              in_valid,
    output logic              in_ready,
    input  blk_t              in_blk,
    output logic              out_valid,
    input  logic              out_ready,
    output blk_t              out_blk
);

    logic              valid_reg;
    logic              valid_next;
    blk_t              blk_reg;
    blk_t              blk_next;
    logic              dec;
    logic              upd_first;
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] tgt;
    logic [WORD_W-1:0] ka;
    logic [WORD_W-1:0] kb;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] upd;

    // Encryption updates the first half in its first phase; decryption runs
    // the halves in reverse order.
    assign dec       = in_blk.func;
    assign upd_first = (~phase) ^ dec;
    assign src       = upd_first ? in_blk.second : in_blk.first;
    assign tgt       = upd_first ? in_blk.first : in_blk.second;
    assign ka        = upd_first ? key.word0 : key.word2;
    assign kb        = upd_first ? key.word1 : key.word3;
    assign sum       = dec ? sum_dec : sum_enc;
    assign mix       = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
    assign upd       = dec ? (tgt - mix) : (tgt + mix);

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_blk   = blk_reg;

    always_comb
    begin
        valid_next = valid_reg;
        blk_next   = blk_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
            if (in_valid)
            begin
                blk_next      = in_blk;
                if (upd_first)
                begin
                    blk_next.first = upd;
                end
                else
                begin
                    blk_next.second = upd;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

endmodule

>>> src/tea_block_cipher_unit.sv
// Top level of the TEA block cipher unit: key registers and the half-round pipeline.
// Depends on tbc_pkg, tbc_key_regs, tbc_stage and assert_macros.svh.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  s_tdata: in_first, in_second; s_tuser: func
//  m_*      out        m_tvalid/m_tready  m_tdata: out_first, out_second
//  cfg_*    in         cfg_valid/cfg_ready cfg_index, cfg_data (key words 0..3)
//
// Every request passes through 2 * ROUND_COUNT register stages, one per half
// round, and a new request may enter every cycle unless a stall at m_tready has filled the pipeline.
// Each stage holds its own valid bit and takes new data when it is empty or
// when the stage after it moves, so bubbles collapse and a stall at m_tready
// only backs up until the pipeline is full.
// Reset clears the valid bits and the key words; the configuration channel
// is always ready and must only be written while no request is in flight.
`include "assert_macros.svh"

module tea_block_cipher_unit
    import tbc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input request stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [2*WORD_W-1:0]    s_tdata,   // [31:0] in_first, [63:32] in_second
    input  logic                   s_tuser,   // [0] func: 0 encrypt, 1 decrypt
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [2*WORD_W-1:0]    m_tdata,   // [31:0] out_first, [63:32] out_second
    // Key configuration channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data
);

    key_t key;

    // Element 0 is the input side; element i is the output of stage i.
    logic [STAGE_COUNT:0] stage_valid;
    logic [STAGE_COUNT:0] stage_ready;
    blk_t                 stage_blk [STAGE_COUNT+1];

    tbc_key_regs u_key_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key)
    );

    assign stage_valid[0]         = s_tvalid;
    assign s_tready               = stage_ready[0];
    assign stage_blk[0].func      = s_tuser;
    assign stage_blk[0].first     = s_tdata[WORD_W-1:0];
    assign stage_blk[0].second    = s_tdata[2*WORD_W-1:WORD_W];

    // Each round is split into two stages: the first half-update and the
    // second. The round sum is a constant of its stage for either direction.
    for (genvar g = 0; g < STAGE_COUNT; g++)
    begin : g_stage
        localparam int RND = g / 2;
        localparam logic [WORD_W-1:0] SUM_ENC = round_sum(RND);
        localparam logic [WORD_W-1:0] SUM_DEC = round_sum(ROUND_COUNT - 1 - RND);
        localparam logic PHASE = ((g % 2) != 0);

        tbc_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .key       (key),
            .sum_enc   (SUM_ENC),
            .sum_dec   (SUM_DEC),
            .phase     (PHASE),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_blk    (stage_blk[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_blk   (stage_blk[g+1])
        );
    end

    assign m_tvalid                = stage_valid[STAGE_COUNT];
    assign stage_ready[STAGE_COUNT] = m_tready;
    assign m_tdata                 = {stage_blk[STAGE_COUNT].second,
                                      stage_blk[STAGE_COUNT].first};

    // The input side can only be held off when every stage holds a request.
    `ASSERT_CLK(a_stall_only_when_full, clk, rst_n, !s_tready |-> (&stage_valid[STAGE_COUNT:1]))
    // A full pipeline with a stalled output must hold off the input side.
    `ASSERT_CLK(a_full_stall_blocks, clk, rst_n, ((&stage_valid[STAGE_COUNT:1]) && !m_tready) |-> !s_tready)
    // An accepted request lands in the first stage.
    `ASSERT_CLK(a_accept_lands, clk, rst_n, (s_tvalid && s_tready) |=> stage_valid[1])
    // A request in mid pipeline is never dropped while the stage after it waits.
    `ASSERT_CLK(a_mid_hold, clk, rst_n, (stage_valid[ROUND_COUNT] && !stage_ready[ROUND_COUNT]) |=> stage_valid[ROUND_COUNT])

endmodule
